FILE: rtl/nap_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nap_pkg
// Shared widths, register codes, config struct and saturation helper for the
// normalized lms adaptive predictor.
// ----------------------------------------------------------------------------
package nap_pkg;

    localparam int TAPS    = 8;
    localparam int IDX_W   = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int CNT_W   = $clog2(TAPS + 1);
    localparam int SMP_W   = 16;
    localparam int WGT_W   = 48;
    localparam int OUT_W   = 48;
    localparam int ACC_W   = SMP_W + WGT_W + $clog2(TAPS) + 1;
    localparam int EN_W    = 2 * SMP_W - 1 + $clog2(TAPS);
    localparam int DV_W    = EN_W + 17;
    localparam int SAT_W   = ACC_W - 14;
    localparam int RAT_W   = 64;
    localparam int MAG_W   = 64;
    localparam int PP_W    = 128;
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 33;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;

    localparam logic REG_STEP = 1'b0;
    localparam logic REG_BIAS = 1'b1;

    localparam logic [DATA_W-1:0] STEP_RST = 32'h4000_0000;
    localparam logic [DATA_W-1:0] BIAS_RST = 32'h0001_0000;

    typedef struct packed {
        logic [DATA_W-1:0] step;
        logic [DATA_W-1:0] bias;
    } cfg_t;

    function automatic logic signed [OUT_W-1:0] sat48(input logic signed [SAT_W-1:0] v);
        logic signed [OUT_W-1:0] r;
        if ((&v[SAT_W-1:OUT_W-1]) || !(|v[SAT_W-1:OUT_W-1]))
            r = v[OUT_W-1:0];
        else if (v[SAT_W-1])
            r = {1'b1, {(OUT_W-1){1'b0}}};
        else
            r = {1'b0, {(OUT_W-1){1'b1}}};
        return r;
    endfunction

endpackage

FILE: rtl/nap_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nap_if
// Valid/ready channels for incoming samples and outgoing results.
// ----------------------------------------------------------------------------
interface nap_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [nap_pkg::SMP_W-1:0]  sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface nap_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [nap_pkg::OUT_W-1:0]  estimate;
    logic signed [nap_pkg::OUT_W-1:0]  prediction_error;

    modport source (output valid, output estimate, output prediction_error, input ready);
    modport sink   (input valid, input estimate, input prediction_error, output ready);
endinterface

FILE: rtl/nap_apb_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nap_apb_regs
// APB-style register file holding step size and divider constant.
// ----------------------------------------------------------------------------
module nap_apb_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [nap_pkg::ADDR_W-1:0]   paddr,
    input  logic [nap_pkg::DATA_W-1:0]   pwdata,
    output logic [nap_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output nap_pkg::cfg_t                cfg
);
    import nap_pkg::*;

    cfg_t cfg_reg;

    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step <= STEP_RST;
            cfg_reg.bias <= BIAS_RST;
        end
        else if (psel && penable && pwrite && (paddr[1:0] == 2'b00))
        begin
            case (paddr[2])
                REG_STEP: cfg_reg.step <= pwdata;
                REG_BIAS: cfg_reg.bias <= pwdata;
                default:  cfg_reg      <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_STEP: prdata = cfg_reg.step;
            REG_BIAS: prdata = cfg_reg.bias;
            default:  prdata = '0;
        endcase
    end

endmodule

FILE: rtl/nap_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nap_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module nap_mul (
    input  logic                                  clk,
    input  logic signed [nap_pkg::MUL_A_W-1:0]    a,
    input  logic signed [nap_pkg::MUL_B_W-1:0]    b,
    output logic signed [nap_pkg::PROD_W-1:0]     prod
);
    import nap_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

FILE: rtl/nap_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nap_div
// Bit-serial restoring divider forming the Q32.32 adaptation ratio.
// ----------------------------------------------------------------------------
module nap_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [nap_pkg::DATA_W-1:0]    dividend,
    input  logic [nap_pkg::DV_W-1:0]      divisor,
    output logic                          done,
    output logic [nap_pkg::RAT_W-1:0]     ratio
);
    import nap_pkg::*;

    localparam int STEPS = RAT_W + 2;
    localparam int SC_W  = $clog2(STEPS);

    logic [DV_W-1:0]   dvs_reg;
    logic [DV_W-1:0]   rem_reg;
    logic [DATA_W-1:0] sh_reg;
    logic [RAT_W-1:0]  q_reg;
    logic [SC_W-1:0]   cnt_reg;
    logic              busy_reg;
    logic              over_reg;
    logic              zero_reg;
    logic              done_reg;
    logic [DV_W:0]     trial;
    logic              fits;

    assign trial = {rem_reg, sh_reg[DATA_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            over_reg <= 1'b0;
            zero_reg <= 1'b0;
            q_reg    <= '0;
            rem_reg  <= '0;
            sh_reg   <= '0;
            dvs_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= SC_W'(STEPS - 1);
                dvs_reg  <= divisor;
                zero_reg <= (divisor == '0);
                sh_reg   <= dividend;
                rem_reg  <= '0;
                q_reg    <= '0;
                over_reg <= 1'b0;
            end
            else if (busy_reg)
            begin
                sh_reg  <= {sh_reg[DATA_W-2:0], 1'b0};
                rem_reg <= fits ? DV_W'(trial - {1'b0, dvs_reg}) : trial[DV_W-1:0];
                if (cnt_reg >= SC_W'(RAT_W))
                begin
                    if (fits)
                        over_reg <= 1'b1;
                end
                else
                    q_reg <= {q_reg[RAT_W-2:0], fits};
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                    cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    assign done  = done_reg;
    assign ratio = zero_reg ? '0 : (over_reg ? '1 : q_reg);

endmodule

FILE: rtl/nlms_adaptive_predictor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlms_adaptive_predictor
// Normalized lms predictor: dot product, energy, ratio and weight update
// sequenced over one shared multiplier and a bit-serial divider.
//
// channel   dir  handshake           payload
// samples   in   valid/ready         sample
// results   out  valid/ready         estimate, prediction_error
// apb       in   psel/penable/pwrite step, bias
//
// each sample is sequenced through the shared multiplier passes and the
// 66-step divider, with one more weight update once the window is full.
// ready is high only when idle. the result register holds a finished
// result while the next sample is taken; the sequencer waits at its end
// only if that register is still full.
// reset clears window, weights and fill count at once.
// ----------------------------------------------------------------------------
module nlms_adaptive_predictor (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [nap_pkg::ADDR_W-1:0]   paddr,
    input  logic [nap_pkg::DATA_W-1:0]   pwdata,
    output logic [nap_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    nap_in_if.sink                       samples,
    nap_out_if.source                    results
);
    import nap_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_DOT  = 4'd1;
    localparam logic [3:0] ST_EST  = 4'd2;
    localparam logic [3:0] ST_ERR  = 4'd3;
    localparam logic [3:0] ST_DIV  = 4'd4;
    localparam logic [3:0] ST_WM   = 4'd5;
    localparam logic [3:0] ST_WP   = 4'd6;
    localparam logic [3:0] ST_WUPD = 4'd7;
    localparam logic [3:0] ST_FIN  = 4'd8;

    localparam logic [CNT_W-1:0] TAPS_C = CNT_W'(TAPS);
    localparam logic [95:0]      CLAMP  = 96'h1_0000_0000_0000;

    cfg_t cfg;

    logic [3:0]               state_reg;
    logic                     phase_reg;
    logic [CNT_W-1:0]         idx_reg;
    logic [CNT_W-1:0]         fill_reg;
    logic [1:0]               k_reg;
    logic signed [SMP_W-1:0]  x_reg;
    logic signed [SMP_W-1:0]  win_reg [TAPS];
    logic signed [WGT_W-1:0]  wgt_reg [TAPS];
    logic signed [ACC_W-1:0]  acc_reg;
    logic [EN_W-1:0]          energy_reg;
    logic signed [OUT_W-1:0]  est_reg;
    logic signed [OUT_W-1:0]  err_reg;
    logic signed [MAG_W-1:0]  wm_lo_reg;
    logic [MAG_W-1:0]         mag_reg;
    logic                     neg_reg;
    logic [PP_W-1:0]          pp_reg;
    logic                     out_valid_reg;
    logic signed [OUT_W-1:0]  out_est_reg;
    logic signed [OUT_W-1:0]  out_err_reg;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic                      div_start;
    logic                      div_done;
    logic [RAT_W-1:0]          ratio;
    logic [DV_W-1:0]           divisor;

    logic [IDX_W-1:0]          ix;
    logic                      full;
    logic                      last;
    logic signed [SMP_W-1:0]   cur_smp;
    logic signed [WGT_W-1:0]   cur_wgt;
    logic [PP_W-1:0]           pp_add;
    logic signed [ACC_W-1:0]   acc_rnd;
    logic signed [MAG_W-1:0]   m_full;
    logic [95:0]               val_full;
    logic [48:0]               val;
    logic signed [49:0]        delta;
    logic signed [OUT_W-1:0]   new_w;
    logic signed [OUT_W-1:0]   err_next;
    logic signed [OUT_W-1:0]   est_next;
    logic                      out_free;
    logic                      take;

    nap_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    nap_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    nap_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (cfg.step),
        .divisor  (divisor),
        .done     (div_done),
        .ratio    (ratio)
    );

    assign ix       = idx_reg[IDX_W-1:0];
    assign full     = (fill_reg == TAPS_C);
    assign last     = full ? (idx_reg == TAPS_C) : (idx_reg == CNT_W'(TAPS - 1));
    assign cur_smp  = (idx_reg == TAPS_C) ? x_reg : win_reg[ix];
    assign cur_wgt  = (idx_reg == TAPS_C) ? '0 : wgt_reg[ix];
    assign out_free = !out_valid_reg || results.ready;
    assign take     = samples.valid && samples.ready;

    assign samples.ready            = (state_reg == ST_IDLE);
    assign results.valid            = out_valid_reg;
    assign results.estimate         = out_est_reg;
    assign results.prediction_error = out_err_reg;

    assign div_start = (state_reg == ST_ERR);
    assign divisor   = DV_W'({energy_reg, 16'b0}) + DV_W'(cfg.bias);

    // operand select for the shared multiplier, wide operands in two halves
    always_comb
    begin
        case (state_reg)
            ST_DOT:
            begin
                mul_a = MUL_A_W'(win_reg[ix]);
                case (k_reg)
                    2'd0:    mul_b = MUL_B_W'({1'b0, wgt_reg[ix][23:0]});
                    2'd1:    mul_b = MUL_B_W'($signed(wgt_reg[ix][WGT_W-1:24]));
                    default: mul_b = MUL_B_W'(win_reg[ix]);
                endcase
            end
            ST_WM:
            begin
                mul_a = MUL_A_W'(cur_smp);
                mul_b = k_reg[0] ? MUL_B_W'($signed(err_reg[OUT_W-1:24]))
                                 : MUL_B_W'({1'b0, err_reg[23:0]});
            end
            ST_WP:
            begin
                mul_a = {1'b0, k_reg[0] ? mag_reg[63:32] : mag_reg[31:0]};
                mul_b = {1'b0, k_reg[1] ? ratio[63:32] : ratio[31:0]};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        case (k_reg)
            2'd0:    pp_add = {64'b0, prod[63:0]};
            2'd3:    pp_add = {prod[63:0], 64'b0};
            default: pp_add = {32'b0, prod[63:0], 32'b0};
        endcase
    end

    assign acc_rnd  = acc_reg + ACC_W'(32768);
    assign est_next = sat48(SAT_W'($signed(acc_rnd[ACC_W-1:16])));
    assign err_next = sat48(SAT_W'($signed({x_reg, 16'b0})) - SAT_W'(est_reg));
    assign m_full   = wm_lo_reg + (MAG_W'(prod) <<< 24);
    assign val_full = pp_reg[PP_W-1:32];
    assign val      = (val_full > CLAMP) ? CLAMP[48:0] : val_full[48:0];
    assign delta    = neg_reg ? -$signed({1'b0, val}) : $signed({1'b0, val});
    assign new_w    = sat48(SAT_W'(cur_wgt) + SAT_W'(delta));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= 1'b0;
            idx_reg       <= '0;
            fill_reg      <= '0;
            k_reg         <= '0;
            x_reg         <= '0;
            acc_reg       <= '0;
            energy_reg    <= '0;
            est_reg       <= '0;
            err_reg       <= '0;
            wm_lo_reg     <= '0;
            mag_reg       <= '0;
            neg_reg       <= 1'b0;
            pp_reg        <= '0;
            out_valid_reg <= 1'b0;
            out_est_reg   <= '0;
            out_err_reg   <= '0;
            for (int i = 0; i < TAPS; i++)
            begin
                win_reg[i] <= '0;
                wgt_reg[i] <= '0;
            end
        end
        else
        begin
            if (results.valid && results.ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (take)
                    begin
                        x_reg      <= samples.sample;
                        acc_reg    <= '0;
                        energy_reg <= '0;
                        idx_reg    <= '0;
                        k_reg      <= '0;
                        phase_reg  <= 1'b0;
                        state_reg  <= ST_DOT;
                    end
                end
                ST_DOT:
                begin
                    phase_reg <= !phase_reg;
                    if (phase_reg)
                    begin
                        case (k_reg)
                            2'd0:
                            begin
                                acc_reg <= acc_reg + ACC_W'(prod);
                                k_reg   <= 2'd1;
                            end
                            2'd1:
                            begin
                                acc_reg <= acc_reg + (ACC_W'(prod) <<< 24);
                                k_reg   <= 2'd2;
                            end
                            default:
                            begin
                                energy_reg <= energy_reg + prod[EN_W-1:0];
                                k_reg      <= 2'd0;
                                if (idx_reg == CNT_W'(TAPS - 1))
                                    state_reg <= ST_EST;
                                else
                                    idx_reg <= idx_reg + 1'b1;
                            end
                        endcase
                    end
                end
                ST_EST:
                begin
                    est_reg   <= est_next;
                    state_reg <= ST_ERR;
                end
                ST_ERR:
                begin
                    err_reg   <= err_next;
                    idx_reg   <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        phase_reg <= 1'b0;
                        k_reg     <= '0;
                        state_reg <= ST_WM;
                    end
                end
                ST_WM:
                begin
                    phase_reg <= !phase_reg;
                    if (phase_reg)
                    begin
                        if (k_reg == 2'd0)
                        begin
                            wm_lo_reg <= MAG_W'(prod);
                            k_reg     <= 2'd1;
                        end
                        else
                        begin
                            neg_reg   <= m_full[MAG_W-1];
                            mag_reg   <= m_full[MAG_W-1] ? MAG_W'(-m_full) : MAG_W'(m_full);
                            pp_reg    <= '0;
                            k_reg     <= '0;
                            state_reg <= ST_WP;
                        end
                    end
                end
                ST_WP:
                begin
                    phase_reg <= !phase_reg;
                    if (phase_reg)
                    begin
                        pp_reg <= pp_reg + pp_add;
                        if (k_reg == 2'd3)
                            state_reg <= ST_WUPD;
                        else
                            k_reg <= k_reg + 1'b1;
                    end
                end
                ST_WUPD:
                begin
                    if (idx_reg == TAPS_C)
                    begin
                        for (int i = 0; i < TAPS - 1; i++)
                            wgt_reg[i] <= wgt_reg[i + 1];
                        wgt_reg[TAPS - 1] <= new_w;
                    end
                    else
                        wgt_reg[ix] <= new_w;
                    if (last)
                        state_reg <= ST_FIN;
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        phase_reg <= 1'b0;
                        k_reg     <= '0;
                        state_reg <= ST_WM;
                    end
                end
                ST_FIN:
                begin
                    if (out_free)
                    begin
                        if (full)
                        begin
                            for (int i = 0; i < TAPS - 1; i++)
                                win_reg[i] <= win_reg[i + 1];
                            win_reg[TAPS - 1] <= x_reg;
                        end
                        else
                        begin
                            win_reg[fill_reg[IDX_W-1:0]] <= x_reg;
                            fill_reg <= fill_reg + 1'b1;
                        end
                        out_est_reg   <= est_reg;
                        out_err_reg   <= err_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= TAPS_C)
        else $error("fill count beyond tap count");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> !samples.ready)
        else $error("ready still high after a request was taken");

    a_div_in_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside its wait state");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN) && !out_free |=> (state_reg == ST_FIN))
        else $error("sequencer left its end while the result register was full");

endmodule

FILE: bench/nlms_adaptive_predictor_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlms_adaptive_predictor_test
// Self-checking bench for the normalized lms predictor. A directed table and
// phases of random samples are fed under several step size / divider settings
// while both channels stall at random. Each result is checked against an
// in-bench model of window, weights and ratio arithmetic or a typed table row.
// ----------------------------------------------------------------------------
module nlms_adaptive_predictor_test;

    import nap_pkg::*;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        bit                       is_cfg;
        logic [DATA_W-1:0]        step;
        logic [DATA_W-1:0]        divc;
        logic signed [SMP_W-1:0]  sample;
        bit                       typed;
        logic signed [OUT_W-1:0]  est;
        logic signed [OUT_W-1:0]  err;
    } row_t;

    typedef struct {
        logic signed [OUT_W-1:0] est;
        logic signed [OUT_W-1:0] err;
    } result_t;

    localparam int LIMIT    = 4000;
    localparam int PHASES   = 12;
    localparam int PER_PHASE = 152;

    localparam logic [ADDR_W-1:0] ADDR_STEP = {REG_STEP, 2'b00};
    localparam logic [ADDR_W-1:0] ADDR_DIV  = {REG_BIAS, 2'b00};

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    nap_in_if  samples_if ();
    nap_out_if results_if ();

    nlms_adaptive_predictor i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .samples (samples_if.sink),
        .results (results_if.source)
    );

    always #2 clk = ~clk;

    // model state
    logic [DATA_W-1:0]        m_step = STEP_RST;
    logic [DATA_W-1:0]        m_divc = BIAS_RST;
    logic signed [SMP_W-1:0]  m_win [TAPS];
    logic signed [WGT_W-1:0]  m_wgt [TAPS];
    int                       m_fill = 0;

    result_t pending_q [$];
    int      errors = 0;
    int      idle_cycles = 0;
    int      n_in = 0;
    int      n_out = 0;
    int      n_cfg = 0;
    bit      burst = 1'b0;

    function automatic logic signed [OUT_W-1:0] clamp48(input wide_t v);
        if (v > wide_t'(48'sh7FFF_FFFF_FFFF))
            return 48'sh7FFF_FFFF_FFFF;
        if (v < -wide_t'(48'sh7FFF_FFFF_FFFF) - 1)
            return {1'b1, 47'b0};
        return v[OUT_W-1:0];
    endfunction

    function automatic wide_t scale_by_ratio(input logic [63:0] ratio, input wide_t m);
        logic [127:0] mag;
        logic [127:0] p;
        mag = (m < 0) ? -m : m;
        p = (mag * {64'b0, ratio}) >> 32;
        if (p > (128'd1 << 48))
            p = 128'd1 << 48;
        return (m < 0) ? -$signed(p) : $signed(p);
    endfunction

    function automatic result_t predict_and_adapt(input logic signed [SMP_W-1:0] x);
        result_t r;
        wide_t   acc;
        wide_t   energy;
        wide_t   den;
        wide_t   q;
        wide_t   e;
        logic [63:0] ratio;
        acc = 0;
        energy = 0;
        for (int i = 0; i < TAPS; i++)
        begin
            acc += wide_t'(m_win[i]) * wide_t'(m_wgt[i]);
            energy += wide_t'(m_win[i]) * wide_t'(m_win[i]);
        end
        r.est = clamp48((acc + 32768) >>> 16);
        e = wide_t'(x) * 65536 - wide_t'(r.est);
        r.err = clamp48(e);
        den = (energy <<< 16) + wide_t'({1'b0, m_divc});
        if (den == 0)
            ratio = '0;
        else
        begin
            q = (wide_t'({1'b0, m_step}) <<< 34) / den;
            ratio = (q >= (wide_t'(1) <<< 64)) ? '1 : q[63:0];
        end
        for (int i = 0; i < TAPS; i++)
            m_wgt[i] = clamp48(wide_t'(m_wgt[i])
                               + scale_by_ratio(ratio, wide_t'(m_win[i]) * wide_t'(r.err)));
        if (m_fill < TAPS)
        begin
            m_win[m_fill] = x;
            m_fill++;
        end
        else
        begin
            for (int i = 0; i < TAPS - 1; i++)
            begin
                m_win[i] = m_win[i + 1];
                m_wgt[i] = m_wgt[i + 1];
            end
            m_win[TAPS - 1] = x;
            m_wgt[TAPS - 1] = clamp48(scale_by_ratio(ratio, wide_t'(x) * wide_t'(r.err)));
        end
        return r;
    endfunction

    task automatic report(input string what, input logic signed [OUT_W-1:0] got,
                          input logic signed [OUT_W-1:0] want);
        $display("mismatch %s at result %0d: got %0d want %0d", what, n_out, got, want);
        errors++;
    endtask

    function automatic int pick_gap();
        int k;
        if (burst)
            return 0;
        k = $urandom_range(0, 19);
        if (k < 10)
            return 0;
        if (k < 18)
            return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    function automatic logic signed [SMP_W-1:0] pick_sample();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0)
            return 16'sh7FFF;
        if (k == 1)
            return 16'sh8000;
        if (k < 5)
            return SMP_W'($urandom_range(0, 128) - 64);
        return SMP_W'($urandom);
    endfunction

    function automatic logic [DATA_W-1:0] pick_reg(input logic [DATA_W-1:0] typical);
        int k;
        k = $urandom_range(0, 9);
        if (k == 0)
            return '0;
        if (k == 1)
            return '1;
        if (k < 5)
            return typical;
        return $urandom;
    endfunction

    task automatic apb_write(input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= d;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (a == ADDR_STEP)
            m_step = d;
        else
            m_divc = d;
        n_cfg++;
    endtask

    task automatic drain();
        samples_if.valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_regs(input logic [DATA_W-1:0] step, input logic [DATA_W-1:0] divc);
        drain();
        apb_write(ADDR_STEP, step);
        apb_write(ADDR_DIV, divc);
    endtask

    task automatic send(input logic signed [SMP_W-1:0] x, input bit typed,
                        input logic signed [OUT_W-1:0] est, input logic signed [OUT_W-1:0] err);
        int      g;
        result_t r;
        g = pick_gap();
        if (g > 0)
        begin
            samples_if.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        samples_if.valid  <= 1'b1;
        samples_if.sample <= x;
        do
            @(posedge clk);
        while (!samples_if.ready);
        r = predict_and_adapt(x);
        if (typed)
        begin
            r.est = est;
            r.err = err;
        end
        pending_q.push_back(r);
        n_in++;
    endtask

    // directed table: zero divider on an empty window, field extremes, a full
    // window flushed back to zero, then a large step pushing weights to saturation
    row_t directed [] = '{
        '{1, STEP_RST, 32'h0, 0, 0, 0, 0},
        '{0, 0, 0, 16'sh7FFF, 1, 48'sh0, 48'sh7FFF_0000},
        '{0, 0, 0, 16'sh8000, 0, 0, 0},
        '{0, 0, 0, 16'sh0000, 0, 0, 0},
        '{0, 0, 0, 16'sh0001, 0, 0, 0},
        '{0, 0, 0, 16'shFFFF, 0, 0, 0},
        '{0, 0, 0, 16'sh7FFF, 0, 0, 0},
        '{0, 0, 0, 16'sh8000, 0, 0, 0},
        '{0, 0, 0, 16'sh5555, 0, 0, 0},
        '{0, 0, 0, 16'shAAAA, 0, 0, 0},
        '{0, 0, 0, 16'sh0000, 0, 0, 0},
        '{0, 0, 0, 16'sh0000, 0, 0, 0},
        '{0, 0, 0, 16'sh0000, 0, 0, 0},
        '{0, 0, 0, 16'sh0000, 0, 0, 0},
        '{0, 0, 0, 16'sh0000, 0, 0, 0},
        '{0, 0, 0, 16'sh0000, 0, 0, 0},
        '{0, 0, 0, 16'sh0000, 0, 0, 0},
        '{0, 0, 0, 16'sh0000, 0, 0, 0},
        '{0, 0, 0, 16'sh1234, 0, 0, 0},
        '{1, 32'hFFFF_FFFF, 32'h0000_0001, 0, 0, 0, 0},
        '{0, 0, 0, 16'sh7FFF, 0, 0, 0},
        '{0, 0, 0, 16'sh8000, 0, 0, 0},
        '{0, 0, 0, 16'sh7FFF, 0, 0, 0},
        '{0, 0, 0, 16'sh8000, 0, 0, 0},
        '{0, 0, 0, 16'sh7FFF, 0, 0, 0},
        '{0, 0, 0, 16'sh8000, 0, 0, 0}
    };

    initial
    begin
        for (int i = 0; i < TAPS; i++)
        begin
            m_win[i] = '0;
            m_wgt[i] = '0;
        end
        samples_if.valid  = 1'b0;
        samples_if.sample = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            if (directed[i].is_cfg)
                set_regs(directed[i].step, directed[i].divc);
            else
                send(directed[i].sample, directed[i].typed, directed[i].est, directed[i].err);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            if (p == 0)
                set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF);
            else if (p == 1)
                set_regs(32'h0, 32'h0);
            else
                set_regs(pick_reg(STEP_RST >> $urandom_range(0, 8)),
                         pick_reg(BIAS_RST << $urandom_range(0, 8)));
            for (int n = 0; n < PER_PHASE; n++)
            begin
                if ($urandom_range(0, 39) == 0)
                    burst = ~burst;
                send(pick_sample(), 1'b0, '0, '0);
            end
        end

        drain();
        repeat (250) @(posedge clk);
        $display("covered %0d samples and %0d results over %0d register writes,",
                 n_in, n_out, n_cfg);
        $display("including zero divider, saturating weights and full-window shifts");
        if (errors == 0 && pending_q.size() == 0)
            $display("nlms_adaptive_predictor_test: clean");
        else
        begin
            if (pending_q.size() != 0)
                $display("%0d results never arrived", pending_q.size());
            $display("nlms_adaptive_predictor_test: errors");
        end
        $finish;
    end

    // result side stalls: alternating ready runs of random length
    initial
    begin
        int  k;
        int  len;
        bit  r;
        results_if.ready = 1'b0;
        r = 1'b0;
        forever
        begin
            k = $urandom_range(0, 19);
            r = ~r;
            if (k < 12)
                len = $urandom_range(1, 4);
            else if (k < 19)
                len = $urandom_range(5, 40);
            else
                len = $urandom_range(100, 300);
            results_if.ready <= r;
            repeat (len) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && results_if.valid && results_if.ready)
        begin
            n_out++;
            if (pending_q.size() == 0)
                report("unexpected estimate", results_if.estimate, '0);
            else
            begin
                want = pending_q.pop_front();
                if (results_if.estimate !== want.est)
                    report("estimate", results_if.estimate, want.est);
                if (results_if.prediction_error !== want.err)
                    report("prediction_error", results_if.prediction_error, want.err);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((samples_if.valid && samples_if.ready) || (results_if.valid && results_if.ready)
            || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= LIMIT)
        begin
            $display("watchdog: no request moved for %0d cycles", LIMIT);
            $display("nlms_adaptive_predictor_test: errors");
            $finish;
        end
    end

endmodule

FILE: filelist.f
rtl/nap_pkg.sv
rtl/nap_if.sv
rtl/nap_apb_regs.sv
rtl/nap_mul.sv
rtl/nap_div.sv
rtl/nlms_adaptive_predictor.sv
bench/nlms_adaptive_predictor_test.sv
